@@ rtl/mprf_pkg.sv @@
// Package for the multi-pipe ring FIFO: sizes, operation and status codes,
// and the command/status structs between controller and datapath. No dependencies.
package mprf_pkg;
    localparam int PIPE_COUNT = 16;
    localparam int PIPE_DEPTH = 1024;
    localparam int PID_W      = 4;
    localparam int PTR_W      = $clog2(PIPE_DEPTH);
    localparam int LVL_W      = $clog2(PIPE_DEPTH + 1);
    localparam int ADDR_W     = $clog2(PIPE_COUNT * PIPE_DEPTH);
    localparam int SEL_W      = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
    localparam int CNT_W      = 11;
    localparam logic [CNT_W-1:0] PROGRESS_MAX = 11'd2047;

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_NBWR   = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;
    localparam logic [2:0] OP_FLUSH  = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_BLOCK   = 3'd3;
    localparam logic [2:0] ST_NOFREE  = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [2:0] ST_PARTIAL = 3'd6;

    typedef struct packed {
        logic [2:0] op;
        logic [PID_W-1:0] pipe_id;
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_data;
        logic [PID_W-1:0] new_pipe;
        logic [CNT_W-1:0] byte_count;
        logic       wake_reader;
        logic       wake_writer;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic execute;   // apply the latched item this cycle
        logic capture;   // latch the input item
        logic take_rd;   // registered RAM read data is valid now
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic needs_rd;  // latched item is a successful read
    } t_stat;
endpackage

@@ rtl/mprf_if.sv @@
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type is a type parameter.
interface mprf_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/mprf_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module mprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/mprf_ctrl.sv @@
// Controller state machine: sequences accept, execute, RAM read and result.
// Depends on mprf_pkg.
module mprf_ctrl import mprf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RDWAIT, S_OUT} t_state;
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state = i_stat.needs_rd ? S_RDWAIT : S_OUT;
            end
            S_RDWAIT: begin
                o_cmd.take_rd = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
endmodule

@@ rtl/mprf_dp.sv @@
// Datapath: per-pipe pointer/level/flag registers, byte store RAM and result.
// Depends on mprf_pkg and mprf_ram.
module mprf_dp import mprf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_item   i_item,
    output t_stat   o_stat,
    output t_result o_result
);
    logic [PTR_W-1:0] r_rptr [PIPE_COUNT];
    logic [PTR_W-1:0] r_wptr [PIPE_COUNT];
    logic [LVL_W-1:0] r_lvl  [PIPE_COUNT];
    logic [PIPE_COUNT-1:0] r_alloc, r_rwait, r_wwait;
    logic [CNT_W-1:0] r_prog;
    t_item   r_item;
    t_result r_res;

    logic [SEL_W-1:0] sel;
    logic             valid_id, full, empty, do_wr, do_rd;
    logic             found;
    logic [SEL_W-1:0] free_idx;
    logic [PTR_W-1:0] cur_w, cur_r;
    logic [LVL_W-1:0] cur_l;
    logic [7:0]       ram_q;
    logic [ADDR_W-1:0] ram_addr;
    logic [CNT_W-1:0] prog_inc;
    t_result          res;

    assign sel      = r_item.pipe_id[SEL_W-1:0];
    assign valid_id = ({{(32-PID_W){1'b0}}, r_item.pipe_id} < PIPE_COUNT) && r_alloc[sel];
    assign cur_w    = r_wptr[sel];
    assign cur_r    = r_rptr[sel];
    assign cur_l    = r_lvl[sel];
    assign full     = (cur_l == LVL_W'(PIPE_DEPTH));
    assign empty    = (cur_l == '0);
    assign prog_inc = (r_prog == PROGRESS_MAX) ? r_prog : r_prog + 1'b1;
    assign do_wr = valid_id && (((r_item.op == OP_WRITE) || (r_item.op == OP_NBWR)) && !full);
    assign do_rd = valid_id && (r_item.op == OP_READ) && !empty;
    assign o_stat.needs_rd = do_rd;

    always_comb begin
        found = 1'b0;
        free_idx = '0;
        for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                found = 1'b1;
                free_idx = SEL_W'(i);
            end
        end
    end

    assign ram_addr = ADDR_W'(sel) * ADDR_W'(PIPE_DEPTH) + ADDR_W'(do_wr ? cur_w : cur_r);

    mprf_ram #(.WIDTH(8), .DEPTH(PIPE_COUNT * PIPE_DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.execute && do_wr),
        .i_addr (ram_addr),
        .i_wdata(r_item.data),
        .o_rdata(ram_q)
    );

    always_comb begin
        res = '0;
        res.status = ST_INVALID;
        case (r_item.op)
            OP_CREATE: begin
                res.status   = found ? ST_OK : ST_NOFREE;
                res.new_pipe = PID_W'(free_idx);
            end
            OP_WRITE, OP_READ: begin
                if (valid_id) begin
                    if ((r_item.op == OP_WRITE) ? full : empty) begin
                        res.status     = (r_prog != '0) ? ST_PARTIAL : ST_BLOCK;
                        res.byte_count = r_prog;
                    end else begin
                        res.status      = r_item.last ? ST_DONE : ST_OK;
                        res.byte_count  = r_item.last ? prog_inc : '0;
                        res.wake_reader = do_wr && empty && r_rwait[sel];
                        res.wake_writer = do_rd && full && r_wwait[sel];
                    end
                end
            end
            OP_NBWR: begin
                if (valid_id) begin
                    res.status      = full ? ST_FULL : ST_DONE;
                    res.byte_count  = full ? '0 : CNT_W'(1);
                    res.wake_reader = do_wr && empty && r_rwait[sel];
                end
            end
            OP_QUERY: begin
                if (valid_id) begin
                    res.status     = ST_OK;
                    res.byte_count = CNT_W'(cur_l);
                end
            end
            OP_FLUSH: begin
                if (valid_id) res.status = ST_OK;
            end
            default: res.status = ST_INVALID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_item;
        if (i_cmd.execute) r_res <= res;
        if (i_cmd.take_rd) r_res.read_data <= ram_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
            r_rwait <= '0;
            r_wwait <= '0;
            r_prog  <= '0;
            for (int i = 0; i < PIPE_COUNT; i++) begin
                r_rptr[i] <= '0;
                r_wptr[i] <= '0;
                r_lvl[i]  <= '0;
            end
        end else if (i_cmd.execute) begin
            case (r_item.op)
                OP_CREATE: begin
                    if (found) begin
                        r_alloc[free_idx] <= 1'b1;
                        r_rwait[free_idx] <= 1'b0;
                        r_wwait[free_idx] <= 1'b0;
                        r_rptr[free_idx]  <= '0;
                        r_wptr[free_idx]  <= '0;
                        r_lvl[free_idx]   <= '0;
                    end
                end
                OP_WRITE, OP_READ, OP_NBWR: begin
                    if (r_item.op != OP_NBWR) begin
                        if (!valid_id) begin
                            r_prog <= '0;
                        end else if (do_wr || do_rd) begin
                            r_prog <= r_item.last ? '0 : prog_inc;
                        end else if (r_prog != '0) begin
                            r_prog <= '0;
                        end else if (r_item.op == OP_WRITE) begin
                            r_wwait[sel] <= 1'b1;
                        end else begin
                            r_rwait[sel] <= 1'b1;
                        end
                    end
                    if (do_wr) begin
                        r_wptr[sel] <= (cur_w == PTR_W'(PIPE_DEPTH - 1)) ? '0 : cur_w + 1'b1;
                        r_lvl[sel]  <= cur_l + 1'b1;
                        if (empty) r_rwait[sel] <= 1'b0;
                    end
                    if (do_rd) begin
                        r_rptr[sel] <= (cur_r == PTR_W'(PIPE_DEPTH - 1)) ? '0 : cur_r + 1'b1;
                        r_lvl[sel]  <= cur_l - 1'b1;
                        if (full) r_wwait[sel] <= 1'b0;
                    end
                end
                OP_FLUSH: begin
                    if (valid_id) begin
                        r_rptr[sel] <= '0;
                        r_wptr[sel] <= '0;
                        r_lvl[sel]  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result = r_res;
endmodule

@@ rtl/multi_pipe_ring_fifo.sv @@
// Top level of the multi-pipe ring FIFO: a bank of byte ring FIFOs in one RAM.
// The result is registered: an accepted item is latched, applied in the execute state,
// then offered; a read that takes a byte adds a wait for the registered store read port.
// A new transaction is accepted only once the previous result has been taken.
// Reset is synchronous and active low; pipe state clears at once, the store needs no pass.
module multi_pipe_ring_fifo import mprf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mprf_if.sink   i_in,
    mprf_if.source o_out
);
    t_cmd  cmd;
    t_stat stat;
    t_result res;

    // The controller owns the handshakes; the datapath owns all pipe state.
    mprf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_out_ready(o_out.ready),
        .o_out_valid(o_out.valid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mprf_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in.payload),
        .o_stat  (stat),
        .o_result(res)
    );

    assign o_out.payload = res;

    // A transaction is never accepted while a result is still on offer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready) else $error("accept while result pending");
    // Every accepted transaction produces a result; the check bounds how late it may come.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> ##3 (o_out.valid || $past(o_out.valid)))
        else $error("result late");
    // Both wake flags never rise on the same result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(res.wake_reader && res.wake_writer)) else $error("double wake");
endmodule
